>>> rtl/dctt_pkg.sv
// Shared types and constants for the delayed-call timer table.
// Used by dctt_ctrl, dctt_dp and delayed_call_timer_table_top; no dependencies.
package dctt_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        FN_ADD      = 3'd0,
        FN_REMOVE   = 3'd1,
        FN_FOREVER  = 3'd2,
        FN_CONTAINS = 3'd3,
        FN_RESTART  = 3'd4,
        FN_TICK     = 3'd5,
        FN_COUNT    = 3'd6,
        FN_NONE     = 3'd7
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] now_ms;
        logic [31:0] period_ms;
        logic [3:0]  handle;
    } req_t;

    typedef struct packed {
        logic       is_expiry;
        logic       ok;
        logic [3:0] timer_handle;
        logic [4:0] active_count;
        logic       finished;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic do_add;
        logic do_drop;
        logic do_forever;
        logic do_restart;
        logic do_rearm;
        logic cnt_inc;
        logic fix_total;
        logic set_ok;
        logic emit_op;
        logic emit_exp;
        logic emit_done;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  idx_end;
        logic  match;
        logic  expired;
        logic  rep_one;
    } sts_t;

endpackage

>>> rtl/dctt_ctrl.sv
// Sequencer for the timer table: decodes a request and steps the datapath.
// Depends on dctt_pkg.
module dctt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  dctt_pkg::sts_t sts,
    output dctt_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_SEARCH   = 6'b000100,
        S_COUNT    = 6'b001000,
        S_EMIT     = 6'b010000,
        S_FIN      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.func)
                    dctt_pkg::FN_ADD:
                    begin
                        cmd.do_add = 1'b1;
                        state_next = S_FIN;
                    end
                    dctt_pkg::FN_REMOVE, dctt_pkg::FN_CONTAINS:
                        state_next = S_SEARCH;
                    dctt_pkg::FN_FOREVER:
                    begin
                        cmd.do_forever = 1'b1;
                        state_next     = S_FIN;
                    end
                    dctt_pkg::FN_RESTART:
                    begin
                        cmd.do_restart = 1'b1;
                        state_next     = S_FIN;
                    end
                    dctt_pkg::FN_TICK:
                        state_next = S_COUNT;
                    default:
                        state_next = S_FIN;
                endcase
            end
            S_SEARCH:
            begin
                if (sts.idx_end)
                    state_next = S_FIN;
                else if (sts.match)
                begin
                    cmd.set_ok  = 1'b1;
                    cmd.do_drop = (sts.func == dctt_pkg::FN_REMOVE);
                    state_next  = S_FIN;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_COUNT:
            begin
                // first pass: count finishing timers so every event carries the final total
                if (sts.idx_end)
                begin
                    cmd.fix_total = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.cnt_inc = sts.expired & sts.rep_one;
                    cmd.idx_inc = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (sts.idx_end)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (sts.expired)
                begin
                    cmd.emit_exp = 1'b1;
                    if (sts.rep_one)
                        cmd.do_drop = 1'b1;   // hold index: next entry moves up
                    else
                    begin
                        cmd.do_rearm = 1'b1;
                        cmd.idx_inc  = 1'b1;
                    end
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_FIN:
            begin
                cmd.emit_op = 1'b1;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/dctt_dp.sv
// Datapath of the timer table: timer stores, active list, free stack, result register.
// Depends on dctt_pkg.
module dctt_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  dctt_pkg::req_t request,
    input  dctt_pkg::cmd_t cmd,
    output dctt_pkg::sts_t sts,
    output logic           result_valid,
    output dctt_pkg::rsp_t result
);

    localparam int SL = dctt_pkg::SLOTS;
    localparam int IW = dctt_pkg::IDX_W;
    localparam int CW = dctt_pkg::CNT_W;

    logic [31:0]   period_reg [SL];
    logic [31:0]   start_reg  [SL];
    logic [15:0]   rep_reg    [SL];
    logic [IW-1:0] order_reg  [SL];
    logic [IW-1:0] free_reg   [SL];

    dctt_pkg::req_t req_reg;
    logic [CW-1:0]  total_reg, free_total_reg, fresh_reg;
    logic [CW-1:0]  idx_reg, cnt_reg, fin_total_reg;
    logic           ok_reg;
    logic [IW-1:0]  rh_reg;
    logic           result_valid_reg;
    dctt_pkg::rsp_t result_reg;

    logic [IW-1:0] cur_t;
    logic [IW-1:0] hnd;
    logic [31:0]   elapsed;
    logic [32:0]   end_sum;
    logic          add_can, from_free, from_fresh, add_ok;
    logic [IW-1:0] add_t;
    logic [IW-1:0] free_top;

    assign hnd      = req_reg.handle[IW-1:0];
    assign cur_t    = order_reg[idx_reg[IW-1:0]];
    assign elapsed  = req_reg.now_ms - start_reg[cur_t];
    assign end_sum  = {1'b0, req_reg.now_ms} + {1'b0, req_reg.period_ms};
    assign free_top = free_total_reg[IW-1:0] - 1'b1;

    assign add_can    = (total_reg < CW'(SL)) && !end_sum[32];
    assign from_free  = (free_total_reg != '0);
    assign from_fresh = (fresh_reg < CW'(SL));
    assign add_ok     = add_can && (from_free || from_fresh);
    assign add_t      = from_free ? free_reg[free_top] : fresh_reg[IW-1:0];

    assign sts.func    = req_reg.func;
    assign sts.idx_end = (idx_reg >= total_reg);
    assign sts.match   = (cur_t == hnd);
    assign sts.expired = (elapsed >= period_reg[cur_t]);
    assign sts.rep_one = (rep_reg[cur_t] == 16'd1);

    // timer stores, request register, status and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= request;
        if (cmd.do_add && add_ok)
        begin
            period_reg[add_t] <= req_reg.period_ms;
            start_reg[add_t]  <= req_reg.now_ms;
            rep_reg[add_t]    <= 16'd1;
            order_reg[total_reg[IW-1:0]] <= add_t;
        end
        if (cmd.do_forever)
            rep_reg[hnd] <= 16'd0;
        if (cmd.do_restart)
            start_reg[hnd] <= req_reg.now_ms;
        if (cmd.do_rearm)
        begin
            start_reg[cur_t] <= req_reg.now_ms;
            if (rep_reg[cur_t] > 16'd1)
                rep_reg[cur_t] <= rep_reg[cur_t] - 16'd1;
        end
        if (cmd.do_drop)
        begin
            if (free_total_reg < CW'(SL))
                free_reg[free_total_reg[IW-1:0]] <= cur_t;
            // close the gap behind the dropped entry
            for (int i = 0; i < SL - 1; i++)
            begin
                if (CW'(i) >= idx_reg)
                    order_reg[i] <= order_reg[i + 1];
            end
        end
        if (cmd.do_add)
        begin
            ok_reg <= add_ok;
            rh_reg <= add_ok ? add_t : '0;
        end
        else if (cmd.load)
        begin
            ok_reg <= 1'b0;
            rh_reg <= '0;
        end
        else if (cmd.set_ok)
            ok_reg <= 1'b1;
        if (cmd.fix_total)
            fin_total_reg <= total_reg - cnt_reg;
        if (cmd.emit_exp)
            result_reg <= '{1'b1, 1'b0, cur_t, fin_total_reg, sts.rep_one, 1'b0};
        else if (cmd.emit_done)
            result_reg <= '{1'b0, 1'b0, 4'd0, total_reg, 1'b0, 1'b1};
        else if (cmd.emit_op)
            result_reg <= '{1'b0, ok_reg, rh_reg, total_reg, 1'b0, 1'b1};
    end

    // list bookkeeping and walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg        <= '0;
            free_total_reg   <= '0;
            fresh_reg        <= '0;
            idx_reg          <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit_exp | cmd.emit_done | cmd.emit_op;
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.load || cmd.fix_total)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.do_add && add_ok)
            begin
                total_reg <= total_reg + 1'b1;
                if (from_free)
                    free_total_reg <= free_total_reg - 1'b1;
                else
                    fresh_reg <= fresh_reg + 1'b1;
            end
            else if (cmd.do_drop)
            begin
                total_reg <= total_reg - 1'b1;
                if (free_total_reg < CW'(SL))
                    free_total_reg <= free_total_reg + 1'b1;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(SL))
        else $error("active total beyond table size");

    a_handles_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, total_reg} + {1'b0, free_total_reg}) == {1'b0, fresh_reg})
        else $error("handle lost or duplicated");

    a_finish_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= total_reg)
        else $error("finish count exceeds active total");

endmodule

>>> rtl/delayed_call_timer_table_top.sv
// Top level of the delayed-call timer table.
// Depends on dctt_pkg, dctt_ctrl and dctt_dp.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------
//  request   | start && !busy       | request (func, now_ms, period_ms, handle)
//  result    | result_valid strobe  | result (is_expiry, ok, timer_handle,
//            |                      |   active_count, finished, last)
//
// Add, set forever, restart and count pass from dispatch straight to the final
// state and one result. Remove and contains walk the active list one entry a
// cycle until a match or the end. A tick walks the list twice (one pass counts
// finishing timers, one emits events).
// Reset clears the list counters and the sequencer; stores are written before use.
// Results appear at most one per cycle, each valid for one cycle; the receiver cannot stall.
// busy stays high until the last result of a request has been issued.
module delayed_call_timer_table_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  dctt_pkg::req_t request,
    output logic           result_valid,
    output dctt_pkg::rsp_t result
);

    dctt_pkg::cmd_t cmd;
    dctt_pkg::sts_t sts;

    // sequencer: decode the request and advance through the walk
    dctt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // stores, active list, free stack and the result register
    dctt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
